// ----- hdl/rhc_pkg.sv -----
`default_nettype none
package rhc_pkg;

  // default sizes
  localparam int BUCKETS_DEF  = 127;
  localparam int ENTRIES_DEF  = 64;
  localparam int REF_BITS_DEF = 16;

  // reset value of the keep time register
  localparam logic [7:0] KEEP_RESET = 8'd5;

  // field widths
  localparam int KEY_W  = 32;
  localparam int BKT_W  = 10;   // enough for the largest bucket count

  // entry flag bits
  localparam int FL_ALLOC  = 0;
  localparam int FL_USABLE = 1;
  localparam int FL_FREE   = 2;

  typedef enum logic [2:0] {
    CMD_FIND    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_ADDREF  = 3'd3,
    CMD_FLUSH   = 3'd4,
    CMD_TICK    = 3'd5
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    BS_INIT,
    BS_IDLE,
    BS_FND_HEAD,
    BS_FND_FIRST,
    BS_FND_EVAL,
    BS_ADD_SCAN,
    BS_ADD_WR,
    BS_RA_RD,
    BS_RA_UPD,
    BS_EMIT,
    BS_SW_HEAD,
    BS_SW_FIRST,
    BS_SW_EVAL,
    BS_SW_END
  } back_state_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_code_t          command;
    logic [31:0]        key;
    logic [31:0]        service;
    logic [31:0]        payload;
    logic               has_free;
    logic [5:0]         entry_index;
    logic               terminating;
    logic [BKT_W-1:0]   bucket;
  } req_t;

  // one result
  typedef struct packed {
    status_t     status;
    logic [5:0]  index;
    logic [31:0] payload;
    logic        removed;
    logic        call_free;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/rhc_fifo.sv -----
`default_nettype none
module rhc_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire T     din,
  output logic      full,
  input  wire logic pop,
  output T          dout,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CNTW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rhc_front.sv -----
`default_nettype none
module rhc_front #(
  parameter int BUCKETS = rhc_pkg::BUCKETS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] key,
  input  wire logic [31:0] service,
  input  wire logic [31:0] payload,
  input  wire logic        has_free,
  input  wire logic [5:0]  entry_index,
  input  wire logic        terminating,
  output logic             q_push,
  output rhc_pkg::req_t    q_din,
  input  wire logic        q_full
);

  // reciprocal of the bucket count, rounded up, scaled by 2^(32 + ceil(log2 BUCKETS))
  localparam int SHIFT = 32 + $clog2(BUCKETS);
  localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [15:0] RECIP_LO = RECIP[15:0];
  localparam logic [16:0] RECIP_HI = RECIP[32:16];

  rhc_pkg::req_t             hold;
  logic                      busy;
  logic                      done;
  logic [1:0]                cnt;
  logic [47:0]               prod_lo;
  logic [48:0]               prod_hi;
  logic [64:0]               prod;
  logic [31:0]               quo;
  logic [rhc_pkg::BKT_W-1:0] bkt;
  logic                      known;

  assign full   = busy;
  assign known  = (command <= 3'(rhc_pkg::CMD_TICK));
  assign q_push = busy && done;
  assign prod   = {prod_hi, 16'd0} + 65'(prod_lo);

  always_comb begin
    q_din        = hold;
    q_din.bucket = bkt;
  end

  // accept, classify and compute the bucket
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (!busy) begin
      if (push && known) begin
        busy <= 1'b1;
        done <= 1'b0;
      end
    end else if (!done) begin
      if (cnt == 2'd2) begin
        done <= 1'b1;
      end
    end else if (!q_full) begin
      busy <= 1'b0;
    end
  end

  // payload of the request under work and the bucket by reciprocal multiplication
  always_ff @(posedge clk) begin
    if (!busy) begin
      hold.command     <= rhc_pkg::cmd_code_t'(command);
      hold.key         <= key;
      hold.service     <= service;
      hold.payload     <= payload;
      hold.has_free    <= has_free;
      hold.entry_index <= entry_index;
      hold.terminating <= terminating;
      hold.bucket      <= '0;
      cnt              <= '0;
    end else if (!done) begin
      case (cnt)
        // partial products of key times reciprocal
        2'd0: begin
          prod_lo <= 48'(hold.key) * 48'(RECIP_LO);
          prod_hi <= 49'(hold.key) * 49'(RECIP_HI);
        end
        // quotient
        2'd1: begin
          quo <= 32'(prod >> SHIFT);
        end
        // remainder
        default: begin
          bkt <= rhc_pkg::BKT_W'(hold.key - quo * 32'(BUCKETS));
        end
      endcase
      cnt <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rhc_back.sv -----
`default_nettype none
module rhc_back #(
  parameter int BUCKETS  = rhc_pkg::BUCKETS_DEF,
  parameter int ENTRIES  = rhc_pkg::ENTRIES_DEF,
  parameter int REF_BITS = rhc_pkg::REF_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    keep_ticks,
  input  wire rhc_pkg::req_t q_dout,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               out_push,
  output rhc_pkg::res_t      out_data,
  input  wire logic          out_full
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int NW  = $clog2(ENTRIES + 1);
  localparam int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NCH = (ENTRIES + 7) / 8;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [NW-1:0] NULL_IDX = NW'(ENTRIES);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  rhc_pkg::back_state_t state, state_next;

  // control and working registers
  rhc_pkg::req_t     c, c_next;
  logic [IW-1:0]     cur, cur_next;
  logic [NW-1:0]     prev, prev_next;
  logic [BKW-1:0]    sb, sb_next;
  logic [BKW-1:0]    clr, clr_next;
  logic [CW-1:0]     chunk, chunk_next;
  logic [IW-1:0]     slot, slot_next;
  rhc_pkg::res_t     res, res_next;
  logic              res_valid, res_valid_next;
  logic [31:0]       epoch, epoch_next;
  logic [2:0]        flags [ENTRIES];

  // memories
  logic [NW-1:0]       head [BUCKETS];
  logic [NW-1:0]       e_next [ENTRIES];
  logic [31:0]         e_key [ENTRIES];
  logic [31:0]         e_svc [ENTRIES];
  logic [31:0]         e_pay [ENTRIES];
  logic [REF_BITS-1:0] e_refs [ENTRIES];
  logic [31:0]         e_stamp [ENTRIES];

  logic [NW-1:0]       hd_rdata;
  logic [NW-1:0]       rd_next;
  logic [31:0]         rd_key;
  logic [31:0]         rd_svc;
  logic [31:0]         rd_pay;
  logic [REF_BITS-1:0] rd_refs;
  logic [31:0]         rd_stamp;

  // memory strobes
  logic [BKW-1:0]      hd_raddr;
  logic                hd_we;
  logic [BKW-1:0]      hd_waddr;
  logic [NW-1:0]       hd_wdata;
  logic [IW-1:0]       e_raddr;
  logic                nx_we;
  logic [IW-1:0]       nx_waddr;
  logic [NW-1:0]       nx_wdata;
  logic                ent_we;
  logic                refs_we;
  logic [IW-1:0]       refs_waddr;
  logic [REF_BITS-1:0] refs_wdata;
  logic                stamp_we;
  logic [IW-1:0]       stamp_waddr;
  logic                fl_we;
  logic [IW-1:0]       fl_idx;
  logic [2:0]          fl_wdata;

  // derived values
  logic [BKW-1:0]      b;
  logic [IW-1:0]       ei;
  logic                ei_bad;
  logic                svc_hit;
  logic                aged;
  logic                drop;
  logic                stall;
  logic                found;
  logic [IW-1:0]       fidx;
  rhc_pkg::res_t       miss_res;

  assign b       = c.bucket[BKW-1:0];
  assign ei      = c.entry_index[IW-1:0];
  assign ei_bad  = (32'(c.entry_index) >= ENTRIES) || !flags[ei][rhc_pkg::FL_ALLOC];
  assign svc_hit = (c.service == '0) || (c.service == rd_svc);
  assign aged    = ((rd_stamp + 32'(keep_ticks)) < epoch);
  assign drop    = (c.command == rhc_pkg::CMD_FLUSH) ? (svc_hit && rd_refs == '0)
                                                     : (rd_refs == '0 && aged);
  assign stall   = drop && res_valid && out_full;

  always_comb begin
    miss_res        = '0;
    miss_res.status = rhc_pkg::ST_MISS;
    miss_res.last   = 1'b1;
  end

  // first free slot within the current group of eight
  always_comb begin
    logic [31:0] idx;
    found = 1'b0;
    fidx  = '0;
    for (int j = 7; j >= 0; j--) begin
      idx = 32'(chunk) * 8 + 32'(j);
      if (idx < ENTRIES && !flags[idx[IW-1:0]][rhc_pkg::FL_ALLOC]) begin
        found = 1'b1;
        fidx  = idx[IW-1:0];
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rhc_pkg::BS_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state, strobes and working values
  always_comb begin
    state_next     = state;
    c_next         = c;
    cur_next       = cur;
    prev_next      = prev;
    sb_next        = sb;
    clr_next       = clr;
    chunk_next     = chunk;
    slot_next      = slot;
    res_next       = res;
    res_valid_next = res_valid;
    epoch_next     = epoch;
    q_pop          = 1'b0;
    out_push       = 1'b0;
    out_data       = res;
    hd_raddr       = b;
    hd_we          = 1'b0;
    hd_waddr       = b;
    hd_wdata       = NULL_IDX;
    e_raddr        = cur;
    nx_we          = 1'b0;
    nx_waddr       = slot;
    nx_wdata       = hd_rdata;
    ent_we         = 1'b0;
    refs_we        = 1'b0;
    refs_waddr     = cur;
    refs_wdata     = rd_refs;
    stamp_we       = 1'b0;
    stamp_waddr    = cur;
    fl_we          = 1'b0;
    fl_idx         = cur;
    fl_wdata       = '0;

    unique case (state)
      // bucket heads cleared one a cycle
      rhc_pkg::BS_INIT: begin
        hd_we    = 1'b1;
        hd_waddr = clr;
        clr_next = clr + 1'b1;
        if (clr == BKW'(BUCKETS - 1)) begin
          state_next = rhc_pkg::BS_IDLE;
        end
      end

      rhc_pkg::BS_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          c_next = q_dout;
          unique case (q_dout.command)
            rhc_pkg::CMD_FIND: state_next = rhc_pkg::BS_FND_HEAD;
            rhc_pkg::CMD_ADD: begin
              chunk_next = '0;
              state_next = rhc_pkg::BS_ADD_SCAN;
            end
            rhc_pkg::CMD_RELEASE, rhc_pkg::CMD_ADDREF: state_next = rhc_pkg::BS_RA_RD;
            rhc_pkg::CMD_FLUSH, rhc_pkg::CMD_TICK: begin
              sb_next        = '0;
              res_valid_next = 1'b0;
              state_next     = rhc_pkg::BS_SW_HEAD;
            end
            default: state_next = rhc_pkg::BS_IDLE;
          endcase
        end
      end

      // lookup walk
      rhc_pkg::BS_FND_HEAD: begin
        state_next = rhc_pkg::BS_FND_FIRST;
      end

      rhc_pkg::BS_FND_FIRST: begin
        if (hd_rdata == NULL_IDX) begin
          res_next   = miss_res;
          state_next = rhc_pkg::BS_EMIT;
        end else begin
          cur_next   = hd_rdata[IW-1:0];
          e_raddr    = hd_rdata[IW-1:0];
          state_next = rhc_pkg::BS_FND_EVAL;
        end
      end

      rhc_pkg::BS_FND_EVAL: begin
        if (rd_key == c.key && rd_svc == c.service && flags[cur][rhc_pkg::FL_USABLE]) begin
          res_next         = '0;
          res_next.status  = (rd_refs == REF_MAX) ? rhc_pkg::ST_SAT : rhc_pkg::ST_OK;
          res_next.index   = 6'(cur);
          res_next.payload = rd_pay;
          res_next.last    = 1'b1;
          refs_we          = (rd_refs != REF_MAX);
          refs_wdata       = rd_refs + REF_BITS'(1);
          stamp_we         = 1'b1;
          state_next       = rhc_pkg::BS_EMIT;
        end else if (rd_next == NULL_IDX) begin
          res_next   = miss_res;
          state_next = rhc_pkg::BS_EMIT;
        end else begin
          cur_next = rd_next[IW-1:0];
          e_raddr  = rd_next[IW-1:0];
        end
      end

      // free slot search, eight slots a cycle
      rhc_pkg::BS_ADD_SCAN: begin
        if (found) begin
          slot_next  = fidx;
          state_next = rhc_pkg::BS_ADD_WR;
        end else if (chunk == CW'(NCH - 1)) begin
          res_next        = '0;
          res_next.status = rhc_pkg::ST_FULL;
          res_next.last   = 1'b1;
          state_next      = rhc_pkg::BS_EMIT;
        end else begin
          chunk_next = chunk + 1'b1;
        end
      end

      rhc_pkg::BS_ADD_WR: begin
        ent_we      = 1'b1;
        refs_we     = 1'b1;
        refs_waddr  = slot;
        refs_wdata  = REF_BITS'(1);
        stamp_we    = 1'b1;
        stamp_waddr = slot;
        nx_we       = 1'b1;
        hd_we       = 1'b1;
        hd_wdata    = NW'(slot);
        fl_we       = 1'b1;
        fl_idx      = slot;
        fl_wdata    = {c.has_free, 1'b1, 1'b1};
        res_next         = '0;
        res_next.status  = rhc_pkg::ST_OK;
        res_next.index   = 6'(slot);
        res_next.payload = c.payload;
        res_next.last    = 1'b1;
        state_next       = rhc_pkg::BS_EMIT;
      end

      // release and addref
      rhc_pkg::BS_RA_RD: begin
        e_raddr = ei;
        if (ei_bad) begin
          res_next       = miss_res;
          res_next.index = c.entry_index;
          state_next     = rhc_pkg::BS_EMIT;
        end else begin
          state_next = rhc_pkg::BS_RA_UPD;
        end
      end

      rhc_pkg::BS_RA_UPD: begin
        res_next         = '0;
        res_next.index   = c.entry_index;
        res_next.payload = rd_pay;
        res_next.last    = 1'b1;
        refs_waddr       = ei;
        if (c.command == rhc_pkg::CMD_RELEASE) begin
          res_next.status = (rd_refs == '0) ? rhc_pkg::ST_SAT : rhc_pkg::ST_OK;
          refs_we         = (rd_refs != '0);
          refs_wdata      = rd_refs - REF_BITS'(1);
        end else begin
          res_next.status = (rd_refs == REF_MAX) ? rhc_pkg::ST_SAT : rhc_pkg::ST_OK;
          refs_we         = (rd_refs != REF_MAX);
          refs_wdata      = rd_refs + REF_BITS'(1);
        end
        state_next = rhc_pkg::BS_EMIT;
      end

      rhc_pkg::BS_EMIT: begin
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = rhc_pkg::BS_IDLE;
        end
      end

      // flush and tick sweep over all buckets
      rhc_pkg::BS_SW_HEAD: begin
        hd_raddr   = sb;
        state_next = rhc_pkg::BS_SW_FIRST;
      end

      rhc_pkg::BS_SW_FIRST: begin
        prev_next = NULL_IDX;
        if (hd_rdata != NULL_IDX) begin
          cur_next   = hd_rdata[IW-1:0];
          e_raddr    = hd_rdata[IW-1:0];
          state_next = rhc_pkg::BS_SW_EVAL;
        end else if (sb == BKW'(BUCKETS - 1)) begin
          state_next = rhc_pkg::BS_SW_END;
        end else begin
          sb_next    = sb + 1'b1;
          state_next = rhc_pkg::BS_SW_HEAD;
        end
      end

      rhc_pkg::BS_SW_EVAL: begin
        if (!stall) begin
          if (drop) begin
            // unlink and report, flushing out the previous report
            if (prev == NULL_IDX) begin
              hd_we    = 1'b1;
              hd_waddr = sb;
              hd_wdata = rd_next;
            end else begin
              nx_we    = 1'b1;
              nx_waddr = prev[IW-1:0];
              nx_wdata = rd_next;
            end
            out_push           = res_valid;
            res_next           = '0;
            res_next.status    = rhc_pkg::ST_OK;
            res_next.index     = 6'(cur);
            res_next.payload   = rd_pay;
            res_next.removed   = 1'b1;
            res_next.call_free = flags[cur][rhc_pkg::FL_FREE];
            res_valid_next     = 1'b1;
            fl_we              = 1'b1;
          end else begin
            prev_next = NW'(cur);
            if (c.command == rhc_pkg::CMD_FLUSH && svc_hit) begin
              fl_we    = 1'b1;
              fl_wdata = flags[cur];
              fl_wdata[rhc_pkg::FL_USABLE] = 1'b0;
              if (c.terminating) begin
                fl_wdata[rhc_pkg::FL_FREE] = 1'b0;
              end
            end
          end
          if (rd_next != NULL_IDX) begin
            cur_next = rd_next[IW-1:0];
            e_raddr  = rd_next[IW-1:0];
          end else if (sb == BKW'(BUCKETS - 1)) begin
            state_next = rhc_pkg::BS_SW_END;
          end else begin
            sb_next    = sb + 1'b1;
            state_next = rhc_pkg::BS_SW_HEAD;
          end
        end
      end

      rhc_pkg::BS_SW_END: begin
        if (!out_full) begin
          out_push = 1'b1;
          if (res_valid) begin
            out_data      = res;
            out_data.last = 1'b1;
          end else begin
            out_data        = '0;
            out_data.status = rhc_pkg::ST_OK;
            out_data.last   = 1'b1;
          end
          if (c.command == rhc_pkg::CMD_TICK) begin
            epoch_next = epoch + 32'd1;
          end
          res_valid_next = 1'b0;
          state_next     = rhc_pkg::BS_IDLE;
        end
      end

      default: state_next = rhc_pkg::BS_INIT;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      res_valid <= 1'b0;
      epoch     <= 32'd1;
    end else begin
      clr       <= clr_next;
      res_valid <= res_valid_next;
      epoch     <= epoch_next;
    end
    c     <= c_next;
    cur   <= cur_next;
    prev  <= prev_next;
    sb    <= sb_next;
    chunk <= chunk_next;
    slot  <= slot_next;
    res   <= res_next;
  end

  // entry flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        flags[i] <= '0;
      end
    end else if (fl_we) begin
      flags[fl_idx] <= fl_wdata;
    end
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (hd_we) begin
      head[hd_waddr] <= hd_wdata;
    end
    hd_rdata <= head[hd_raddr];
  end

  // chain links
  always_ff @(posedge clk) begin
    if (nx_we) begin
      e_next[nx_waddr] <= nx_wdata;
    end
    rd_next <= e_next[e_raddr];
  end

  // key, service and payload
  always_ff @(posedge clk) begin
    if (ent_we) begin
      e_key[slot] <= c.key;
      e_svc[slot] <= c.service;
      e_pay[slot] <= c.payload;
    end
    rd_key <= e_key[e_raddr];
    rd_svc <= e_svc[e_raddr];
    rd_pay <= e_pay[e_raddr];
  end

  // reference counts
  always_ff @(posedge clk) begin
    if (refs_we) begin
      e_refs[refs_waddr] <= refs_wdata;
    end
    rd_refs <= e_refs[e_raddr];
  end

  // last-use stamps
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      e_stamp[stamp_waddr] <= epoch;
    end
    rd_stamp <= e_stamp[e_raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/refcounted_hash_cache_with_aging.sv -----
`default_nettype none
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------
// request   | push / full                | command key service payload has_free
//           |                            | entry_index terminating
// result    | empty / pop                | status result_index result_payload
//           |                            | removed call_free last
// register  | psel penable pwrite pready | paddr pwdata prdata (keep_ticks at 0-3)
//
// the front holds one request and takes the next once it has passed it on;
// it turns the key into its bucket by product, quotient and remainder steps; find
// walks the bucket chain; add scans free slots eight at a time; release and addref
// end early on a miss; flush and tick sweep every bucket and its chained entries
// after reset all bucket heads are cleared before any request runs
// a full result queue stalls the back end; the front works on until its queue fills
module refcounted_hash_cache_with_aging #(
  parameter int BUCKETS  = rhc_pkg::BUCKETS_DEF,
  parameter int ENTRIES  = rhc_pkg::ENTRIES_DEF,
  parameter int REF_BITS = rhc_pkg::REF_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] key,
  input  wire logic [31:0] service,
  input  wire logic [31:0] payload,
  input  wire logic        has_free,
  input  wire logic [5:0]  entry_index,
  input  wire logic        terminating,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic [5:0]       result_index,
  output logic [31:0]      result_payload,
  output logic             removed,
  output logic             call_free,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic          keep_hit;
  logic [7:0]    keep_ticks;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  rhc_pkg::req_t q_din;
  rhc_pkg::req_t q_dout;
  logic          out_push;
  logic          out_full;
  rhc_pkg::res_t out_data;
  rhc_pkg::res_t out_dout;

  // register port
  assign pready   = 1'b1;
  assign keep_hit = (paddr[2] == 1'b0);
  assign prdata   = keep_hit ? 32'(keep_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_ticks <= rhc_pkg::KEEP_RESET;
    end else if (psel && penable && pwrite && pready && keep_hit) begin
      keep_ticks <= pwdata[7:0];
    end
  end

  // request intake
  rhc_front #(.BUCKETS(BUCKETS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .key         (key),
    .service     (service),
    .payload     (payload),
    .has_free    (has_free),
    .entry_index (entry_index),
    .terminating (terminating),
    .q_push      (q_push),
    .q_din       (q_din),
    .q_full      (q_full)
  );

  // queue between front and back
  rhc_fifo #(.T(rhc_pkg::req_t), .DEPTH(2)) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // table engine
  rhc_back #(
    .BUCKETS  (BUCKETS),
    .ENTRIES  (ENTRIES),
    .REF_BITS (REF_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .keep_ticks (keep_ticks),
    .q_dout     (q_dout),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_push   (out_push),
    .out_data   (out_data),
    .out_full   (out_full)
  );

  // result queue
  rhc_fifo #(.T(rhc_pkg::res_t), .DEPTH(4)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_data),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty)
  );

  assign status         = out_dout.status;
  assign result_index   = out_dout.index;
  assign result_payload = out_dout.payload;
  assign removed        = out_dout.removed;
  assign call_free      = out_dout.call_free;
  assign last           = out_dout.last;

endmodule
`default_nettype wire

// ----- bench/refcounted_hash_cache_with_aging_tb.sv -----
module refcounted_hash_cache_with_aging_tb;

  localparam int NUM_BKT = 127;
  localparam int NUM_ENT = 64;
  localparam logic [6:0] NO_ENTRY = 7'd64;
  localparam logic [15:0] REFS_TOP = 16'hFFFF;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam logic [2:0] ADDR_KEEP = 3'd0;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 600;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [31:0] svc;
    logic [31:0] pay;
    logic        hf;
    logic [5:0]  idx;
    logic        term;
  } cache_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [2:0] command = '0;
  logic [31:0] key = '0;
  logic [31:0] service = '0;
  logic [31:0] payload = '0;
  logic has_free = 1'b0;
  logic [5:0] entry_index = '0;
  logic terminating = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] status;
  logic [5:0] result_index;
  logic [31:0] result_payload;
  logic removed;
  logic call_free;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  refcounted_hash_cache_with_aging i_dut (
    .clk, .rst, .push, .full, .command, .key, .service, .payload, .has_free,
    .entry_index, .terminating, .empty, .pop, .status, .result_index,
    .result_payload, .removed, .call_free, .last, .psel, .penable, .pwrite,
    .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the cache contents
  logic [6:0]  head_of [NUM_BKT];
  logic [6:0]  next_of [NUM_ENT];
  logic [31:0] key_of [NUM_ENT];
  logic [31:0] svc_of [NUM_ENT];
  logic [31:0] pay_of [NUM_ENT];
  logic [15:0] refs_of [NUM_ENT];
  logic [31:0] stamp_of [NUM_ENT];
  logic [2:0]  flags_of [NUM_ENT];
  logic [31:0] epoch_now;
  logic [7:0]  keep_now;

  cache_req_t pending_requests[$];
  rhc_pkg::res_t expected_results[$];
  int errors = 0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic rhc_pkg::res_t make_result(rhc_pkg::status_t st, logic [5:0] idx,
                                                logic [31:0] pay, logic rem, logic cf,
                                                logic lst);
    rhc_pkg::res_t r;
    r.status = st;
    r.index = idx;
    r.payload = pay;
    r.removed = rem;
    r.call_free = cf;
    r.last = lst;
    return r;
  endfunction

  // flush or aging sweep over every bucket chain
  task automatic sweep_chains(bit aging, logic [31:0] sv, bit term);
    int n;
    int steps;
    logic [6:0] prv;
    logic [6:0] cur;
    logic [6:0] nx;
    logic [31:0] due;
    bit drop;
    n = 0;
    for (int b = 0; b < NUM_BKT; b++) begin
      prv = NO_ENTRY;
      cur = head_of[b];
      steps = 0;
      while (cur < NO_ENTRY && steps < NUM_ENT) begin
        nx = next_of[cur];
        drop = 1'b0;
        steps++;
        if (!aging) begin
          if (sv == 0 || sv == svc_of[cur]) begin
            if (refs_of[cur] == 0) begin
              drop = 1'b1;
            end else begin
              if (term) flags_of[cur][rhc_pkg::FL_FREE] = 1'b0;
              flags_of[cur][rhc_pkg::FL_USABLE] = 1'b0;
            end
          end
        end else begin
          due = stamp_of[cur] + {24'd0, keep_now};
          if (refs_of[cur] == 0 && due < epoch_now) drop = 1'b1;
        end
        if (drop) begin
          if (prv == NO_ENTRY) head_of[b] = nx;
          else next_of[prv] = nx;
          expected_results.push_back(make_result(rhc_pkg::ST_OK, cur[5:0], pay_of[cur],
                                                 1'b1, flags_of[cur][rhc_pkg::FL_FREE],
                                                 1'b0));
          n++;
          flags_of[cur] = '0;
        end else begin
          prv = cur;
        end
        cur = nx;
      end
    end
    if (n == 0)
      expected_results.push_back(make_result(rhc_pkg::ST_OK, '0, '0, 1'b0, 1'b0, 1'b1));
    else expected_results[expected_results.size()-1].last = 1'b1;
  endtask

  // expected results of one accepted request
  task automatic predict_request(cache_req_t r);
    int b;
    int steps;
    int s;
    logic [6:0] cur;
    rhc_pkg::status_t st;
    bit hit;
    b = r.key % NUM_BKT;
    case (r.cmd)
      rhc_pkg::CMD_FIND: begin
        cur = head_of[b];
        steps = 0;
        hit = 1'b0;
        while (!hit && cur < NO_ENTRY && steps < NUM_ENT) begin
          steps++;
          if (key_of[cur] == r.key && svc_of[cur] == r.svc &&
              flags_of[cur][rhc_pkg::FL_USABLE]) begin
            hit = 1'b1;
            st = rhc_pkg::ST_OK;
            if (refs_of[cur] == REFS_TOP) st = rhc_pkg::ST_SAT;
            else refs_of[cur]++;
            stamp_of[cur] = epoch_now;
            expected_results.push_back(make_result(st, cur[5:0], pay_of[cur], 1'b0, 1'b0,
                                                   1'b1));
          end else begin
            cur = next_of[cur];
          end
        end
        if (!hit)
          expected_results.push_back(make_result(rhc_pkg::ST_MISS, '0, '0, 1'b0, 1'b0, 1'b1));
      end
      rhc_pkg::CMD_ADD: begin
        s = NUM_ENT;
        for (int i = NUM_ENT - 1; i >= 0; i--) if (!flags_of[i][rhc_pkg::FL_ALLOC]) s = i;
        if (s == NUM_ENT) begin
          expected_results.push_back(make_result(rhc_pkg::ST_FULL, '0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          key_of[s] = r.key;
          svc_of[s] = r.svc;
          pay_of[s] = r.pay;
          refs_of[s] = 16'd1;
          stamp_of[s] = epoch_now;
          flags_of[s] = '0;
          flags_of[s][rhc_pkg::FL_ALLOC] = 1'b1;
          flags_of[s][rhc_pkg::FL_USABLE] = 1'b1;
          flags_of[s][rhc_pkg::FL_FREE] = r.hf;
          next_of[s] = head_of[b];
          head_of[b] = 7'(s);
          expected_results.push_back(make_result(rhc_pkg::ST_OK, 6'(s), r.pay, 1'b0, 1'b0,
                                                 1'b1));
        end
      end
      rhc_pkg::CMD_RELEASE, rhc_pkg::CMD_ADDREF: begin
        if (!flags_of[r.idx][rhc_pkg::FL_ALLOC]) begin
          expected_results.push_back(make_result(rhc_pkg::ST_MISS, r.idx, '0, 1'b0, 1'b0,
                                                 1'b1));
        end else begin
          st = rhc_pkg::ST_OK;
          if (r.cmd == rhc_pkg::CMD_RELEASE) begin
            if (refs_of[r.idx] == 0) st = rhc_pkg::ST_SAT;
            else refs_of[r.idx]--;
          end else begin
            if (refs_of[r.idx] == REFS_TOP) st = rhc_pkg::ST_SAT;
            else refs_of[r.idx]++;
          end
          expected_results.push_back(make_result(st, r.idx, pay_of[r.idx], 1'b0, 1'b0, 1'b1));
        end
      end
      rhc_pkg::CMD_FLUSH: sweep_chains(1'b0, r.svc, r.term);
      rhc_pkg::CMD_TICK: begin
        sweep_chains(1'b1, '0, 1'b0);
        epoch_now = epoch_now + 1;
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(negedge clk) begin
    logic go;
    go = 1'b0;
    if (rst) begin
      go = 1'b0;
    end else if (in_gap > 0) begin
      in_gap--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      in_gap = $urandom_range(0, 4);
    end else begin
      go = pending_requests.size() > 0;
    end
    push <= go;
    if (go) begin
      command <= pending_requests[0].cmd;
      key <= pending_requests[0].key;
      service <= pending_requests[0].svc;
      payload <= pending_requests[0].pay;
      has_free <= pending_requests[0].hf;
      entry_index <= pending_requests[0].idx;
      terminating <= pending_requests[0].term;
    end
  end

  // result consumer
  always @(negedge clk) begin
    logic take;
    take = 1'b0;
    if (rst) begin
      take = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 4);
    end else begin
      take = 1'b1;
    end
    pop <= take;
  end

  // acceptance, checking and watchdog
  always @(posedge clk) begin
    rhc_pkg::res_t want;
    bit moved;
    moved = 1'b0;
    if (!rst && push && !full) begin
      predict_request(pending_requests[0]);
      void'(pending_requests.pop_front());
      moved = 1'b1;
    end
    if (!rst && pop && !empty) begin
      moved = 1'b1;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result_index", 32'(result_index), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (status != want.status) report_mismatch("status", 32'(status), 32'(want.status));
        if (result_index != want.index)
          report_mismatch("result_index", 32'(result_index), 32'(want.index));
        if (result_payload != want.payload)
          report_mismatch("result_payload", result_payload, want.payload);
        if (removed != want.removed)
          report_mismatch("removed", 32'(removed), 32'(want.removed));
        if (call_free != want.call_free)
          report_mismatch("call_free", 32'(call_free), 32'(want.call_free));
        if (last != want.last) report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
    if (moved || (pending_requests.size() == 0 && expected_results.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("refcounted_hash_cache_with_aging_tb failed");
      $finish;
    end
  end

  function automatic cache_req_t build_req(logic [2:0] c, logic [31:0] k, logic [31:0] sv,
                                           logic [31:0] p, logic f, logic [5:0] ix, logic t);
    cache_req_t r;
    r.cmd = c;
    r.key = k;
    r.svc = sv;
    r.pay = p;
    r.hf = f;
    r.idx = ix;
    r.term = t;
    return r;
  endfunction

  function automatic logic [31:0] pick_key();
    logic [31:0] pool [6] = '{32'd5, 32'd132, 32'd259, 32'hFFFF_FFFF, 32'h8000_0000, 32'd42};
    if ($urandom_range(0, 7) == 0) return $urandom;
    return pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [31:0] pick_service();
    logic [31:0] pool [3] = '{32'd1, 32'd2, 32'hFFFF_FFFF};
    if ($urandom_range(0, 9) == 0) return $urandom;
    return pool[$urandom_range(0, 2)];
  endfunction

  // mostly meaningful requests over a small key set, with some noise
  function automatic cache_req_t random_req();
    int w;
    logic [5:0] ix;
    logic [2:0] c;
    w = $urandom_range(0, 99);
    ix = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 11));
    if (w < 30) c = rhc_pkg::CMD_FIND;
    else if (w < 55) c = rhc_pkg::CMD_ADD;
    else if (w < 70) c = rhc_pkg::CMD_RELEASE;
    else if (w < 80) c = rhc_pkg::CMD_ADDREF;
    else if (w < 85) c = rhc_pkg::CMD_FLUSH;
    else if (w < 95) c = rhc_pkg::CMD_TICK;
    else if (w < 97) c = ($urandom_range(0, 1) == 1) ? CMD_SPARE_A : CMD_SPARE_B;
    else c = 3'($urandom_range(0, 5));
    if (w >= 97)
      return build_req(c, $urandom, $urandom, $urandom, 1'($urandom), 6'($urandom), 1'($urandom));
    return build_req(c, pick_key(),
                     (c == rhc_pkg::CMD_FLUSH && $urandom_range(0, 2) == 0) ? 32'd0
                                                                          : pick_service(),
                     $urandom, 1'($urandom), ix, 1'($urandom));
  endfunction

  task automatic write_keep(logic [7:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_KEEP;
    pwdata = {24'd0, v};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    keep_now = v;
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    for (int b = 0; b < NUM_BKT; b++) head_of[b] = NO_ENTRY;
    for (int i = 0; i < NUM_ENT; i++) begin
      next_of[i] = '0;
      key_of[i] = '0;
      svc_of[i] = '0;
      pay_of[i] = '0;
      refs_of[i] = '0;
      stamp_of[i] = '0;
      flags_of[i] = '0;
    end
    epoch_now = 32'd1;
    keep_now = rhc_pkg::KEEP_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2 * NUM_BKT) @(posedge clk);

    // directed: hits, misses, count limits, unknown codes, ageing and flush
    write_keep(8'd0);
    pending_requests.push_back(build_req(rhc_pkg::CMD_FIND, 32'd0, 32'd0, '0, 1'b0, '0, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_ADD, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1,
                                         '0, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                                         1'b0, 6'd63, 1'b1));
    pending_requests.push_back(build_req(rhc_pkg::CMD_ADD, 32'd127, 32'd0, 32'h1234_5678, 1'b1,
                                         '0, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_FIND, 32'd0, 32'd0, '0, 1'b0, '0, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_FIND, 32'd0, 32'd1, '0, 1'b0, '0, 1'b0));
    repeat (3)
      pending_requests.push_back(build_req(rhc_pkg::CMD_RELEASE, '0, '0, '0, 1'b0, 6'd0, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_ADDREF, '0, '0, '0, 1'b0, 6'd63, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_RELEASE, '0, '0, '0, 1'b0, 6'd63, 1'b0));
    pending_requests.push_back(build_req(CMD_SPARE_A, $urandom, $urandom, $urandom, 1'b1,
                                         6'd5, 1'b1));
    pending_requests.push_back(build_req(CMD_SPARE_B, $urandom, $urandom, $urandom, 1'b0,
                                         6'd9, 1'b0));
    repeat (2)
      pending_requests.push_back(build_req(rhc_pkg::CMD_TICK, '0, '0, '0, 1'b0, '0, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_FLUSH, '0, 32'hFFFF_FFFF, '0, 1'b0, '0,
                                         1'b1));
    pending_requests.push_back(build_req(rhc_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0,
                                         1'b0, '0, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_RELEASE, '0, '0, '0, 1'b0, 6'd1, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_FLUSH, '0, 32'd0, '0, 1'b0, '0, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_FLUSH, '0, 32'd0, '0, 1'b0, '0, 1'b0));
    drain();

    // full table, a flush that only marks, then a flush that removes released entries
    write_keep(8'd255);
    repeat (NUM_ENT + 1)
      pending_requests.push_back(build_req(rhc_pkg::CMD_ADD, pick_key(), pick_service(),
                                           $urandom, 1'($urandom), '0, 1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_FLUSH, '0, 32'd0, '0, 1'b0, '0, 1'b1));
    for (int i = 0; i < 16; i++)
      pending_requests.push_back(build_req(rhc_pkg::CMD_RELEASE, '0, '0, '0, 1'b0, 6'(i),
                                           1'b0));
    pending_requests.push_back(build_req(rhc_pkg::CMD_FLUSH, '0, 32'd0, '0, 1'b0, '0, 1'b0));
    drain();

    // random phases over several keep times, the last one without idling
    write_keep(8'd3);
    repeat (24) pending_requests.push_back(random_req());
    drain();
    write_keep(8'($urandom_range(0, 255)));
    repeat (24) pending_requests.push_back(random_req());
    drain();
    write_keep(8'd1);
    repeat (24) pending_requests.push_back(random_req());
    drain();
    calm = 1'b1;
    write_keep(8'd0);
    repeat (24) pending_requests.push_back(random_req());
    drain();

    if (errors == 0) begin
      $display("refcounted_hash_cache_with_aging_tb passed");
    end else begin
      $display("refcounted_hash_cache_with_aging_tb failed");
    end
    $finish;
  end

endmodule
